// ===== rtl/multi_key_debouncer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-key debouncer
// Shared property wrappers, all clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_DEBOUNCER_MACROS_SVH
`define MULTI_KEY_DEBOUNCER_MACROS_SVH

// Property that must hold whenever the block is out of reset.
`define MKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-key debouncer package
// Opcodes, register indexes, reset values and the key state write struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

  // Item opcodes.
  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 1'b1;

  // Field widths.
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PORT_W     = 8;
  localparam int unsigned KEY_IDX_W  = 3;

  // Register reset values.
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [COUNT_W-1:0]    KEY_COUNT_RST = 4'd8;

  // Write request toward the per-key state.
  typedef struct packed {
    logic              level_we;
    logic              level;
    logic [TIME_W-1:0] stamp;
    logic              mark_set;
    logic              mark_clr;
  } key_wr_t;

endpackage

`default_nettype wire

// ===== rtl/multi_key_debouncer.sv =====
// ----------------------------------------------------------------------------
// Multi-key debouncer
// Per-key debounce state for up to MAX_KEYS active-low keys on one port.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while its output is not stalled. A word
// waits in the input register, then the key state lookup, level compare and
// 32-bit elapsed-time subtract settle into the result register. Key state
// lives in flip-flops and is cleared at reset, so the block needs no
// initialisation before the first word. A query word whose key level
// differs from the stored one records the new level and the time and sets the
// change mark; a read word returns and clears that mark. A word whose key index
// is not below key_count (or MAX_KEYS) gives no result and changes nothing.
// Configuration may only be written while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_key_debouncer_macros.svh"

module multi_key_debouncer #(
  parameter int unsigned MAX_KEYS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write channel.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mkd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mkd_pkg::DEBOUNCE_W-1:0]    cfg_data_i,
  // Input channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              opcode_i,
  input  wire logic [mkd_pkg::KEY_IDX_W-1:0]     key_index_i,
  input  wire logic [mkd_pkg::PORT_W-1:0]        port_value_i,
  input  wire logic [mkd_pkg::TIME_W-1:0]        now_ms_i,
  // Output channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   pressed_o,
  output logic [mkd_pkg::TIME_W-1:0]             elapsed_ms_o,
  output logic                                   changed_o,
  output logic                                   new_level_o,
  output logic                                   index_ok_o
);

  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam logic [mkd_pkg::COUNT_W-1:0] KeysLimit = mkd_pkg::COUNT_W'(MAX_KEYS);

  // Configuration registers.
  logic [mkd_pkg::DEBOUNCE_W-1:0] debounce_q;
  logic [mkd_pkg::COUNT_W-1:0]    key_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= mkd_pkg::DEBOUNCE_RST;
      key_count_q <= mkd_pkg::KEY_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mkd_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        mkd_pkg::CFG_KEY_COUNT: key_count_q <= cfg_data_i[mkd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                              s1_valid_q;
  mkd_pkg::op_e                      s1_opcode_q;
  logic [mkd_pkg::KEY_IDX_W-1:0]     s1_key_index_q;
  logic [mkd_pkg::PORT_W-1:0]        s1_port_q;
  logic [mkd_pkg::TIME_W-1:0]        s1_now_q;
  logic                              s1_adv;
  logic                              in_take;

  assign s1_adv     = s1_valid_q && !(out_valid_o && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_opcode_q    <= mkd_pkg::op_e'(opcode_i);
      s1_key_index_q <= key_index_i;
      s1_port_q      <= port_value_i;
      s1_now_q       <= now_ms_i;
    end
  end

  // Key lookup, level compare and elapsed time.
  logic                         idx_ok;
  logic                         cur_level;
  logic                         st_level;
  logic                         st_mark;
  logic [mkd_pkg::TIME_W-1:0]   st_time;
  logic                         lvl_change;
  logic [mkd_pkg::TIME_W-1:0]   stamp_eff;
  logic [mkd_pkg::TIME_W-1:0]   elapsed;
  logic                         is_read;
  logic                         commit;
  mkd_pkg::key_wr_t             key_wr;

  assign idx_ok = ({1'b0, s1_key_index_q} < key_count_q) &&
                  ({1'b0, s1_key_index_q} < KeysLimit);
  assign is_read    = (s1_opcode_q == mkd_pkg::OP_READ);
  assign cur_level  = ~s1_port_q[s1_key_index_q];
  assign lvl_change = (cur_level != st_level);
  assign stamp_eff  = lvl_change ? s1_now_q : st_time;
  assign elapsed    = s1_now_q - stamp_eff;
  assign commit     = s1_adv && idx_ok;

  always_comb begin
    key_wr          = '0;
    key_wr.level    = cur_level;
    key_wr.stamp    = s1_now_q;
    key_wr.level_we = commit && !is_read && lvl_change;
    key_wr.mark_set = commit && !is_read && lvl_change;
    key_wr.mark_clr = commit && is_read;
  end

  mkd_key_bank #(
    .MAX_KEYS(MAX_KEYS)
  ) u_key_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (s1_key_index_q[IdxW-1:0]),
    .wr_i      (key_wr),
    .rd_level_o(st_level),
    .rd_mark_o (st_mark),
    .rd_time_o (st_time)
  );

  // Result register.
  logic                         out_valid_q;
  logic                         pressed_q;
  logic [mkd_pkg::TIME_W-1:0]   elapsed_q;
  logic                         changed_q;
  logic                         new_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (is_read) begin
        pressed_q   <= 1'b0;
        elapsed_q   <= '0;
        changed_q   <= st_mark;
        new_level_q <= st_mark & st_level;
      end else begin
        pressed_q   <= cur_level && (elapsed > {16'd0, debounce_q});
        elapsed_q   <= elapsed;
        changed_q   <= 1'b0;
        new_level_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pressed_o    = pressed_q;
  assign elapsed_ms_o = elapsed_q;
  assign changed_o    = changed_q;
  assign new_level_o  = new_level_q;
  assign index_ok_o   = out_valid_q;

  // Stall only when a word waits behind a blocked result.
  `MKD_ASSERT(a_stall_cause, !in_stall_o || (s1_valid_q && out_valid_o && out_stall_i),
              "input stalled without a blocked result")
  // A pressed report always carries an elapsed time beyond the debounce setting.
  `MKD_ASSERT(a_press_time, !(out_valid_o && pressed_o) || (elapsed_ms_o > {16'd0, debounce_q}),
              "press reported before debounce time")
  // Query and read results never mix their fields.
  `MKD_ASSERT(a_result_kind, !(out_valid_o && (pressed_o || (elapsed_ms_o != '0))) ||
              (!changed_o && !new_level_o), "query and read fields both set")
  // An out-of-range word that leaves the input register must not reach the output.
  `MKD_ASSERT_NEXT(a_drop_range, s1_adv && !idx_ok && !out_valid_o, !out_valid_o,
                   "out-of-range word produced a result")

endmodule

`default_nettype wire

// ===== rtl/mkd_key_bank.sv =====
// ----------------------------------------------------------------------------
// Multi-key debouncer key state bank
// Holds level, change mark and change time for each key in flip-flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_key_debouncer_macros.svh"

module mkd_key_bank #(
  parameter int unsigned MAX_KEYS = 8,
  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [IdxW-1:0]               idx_i,
  input  wire mkd_pkg::key_wr_t              wr_i,
  output logic                               rd_level_o,
  output logic                               rd_mark_o,
  output logic [mkd_pkg::TIME_W-1:0]         rd_time_o
);

  logic [MAX_KEYS-1:0]             level_q;
  logic [MAX_KEYS-1:0]             mark_q;
  logic [mkd_pkg::TIME_W-1:0]      time_q [MAX_KEYS];

  // Per-key state update; only the addressed key takes the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      mark_q  <= '0;
      for (int k = 0; k < MAX_KEYS; k++) begin
        time_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_KEYS; k++) begin
        if (idx_i == IdxW'(k)) begin
          if (wr_i.level_we) begin
            level_q[k] <= wr_i.level;
            time_q[k]  <= wr_i.stamp;
          end
          if (wr_i.mark_set) begin
            mark_q[k] <= 1'b1;
          end else if (wr_i.mark_clr) begin
            mark_q[k] <= 1'b0;
          end
        end
      end
    end
  end

  // Read of the addressed key.
  assign rd_level_o = level_q[idx_i];
  assign rd_mark_o  = mark_q[idx_i];
  assign rd_time_o  = time_q[idx_i];

  // A query sets the mark, a read clears it; one item never does both.
  `MKD_ASSERT(a_mark_excl, !(wr_i.mark_set && wr_i.mark_clr), "mark set and clear together")
  // A level write always comes with a change mark.
  `MKD_ASSERT(a_level_marks, !wr_i.level_we || wr_i.mark_set, "level write without mark")
  // A level write always flips the stored level of that key.
  `MKD_ASSERT(a_level_flips, !wr_i.level_we || (wr_i.level != rd_level_o),
              "level write without a change")

endmodule

`default_nettype wire
